FILE: sv/stick_channel_conditioner_unit_macros.svh
// assertion macros for the stick channel conditioner unit
// expects clk_i and rst_ni in the scope of every use
`ifndef STICK_CHANNEL_CONDITIONER_UNIT_MACROS_SVH
`define STICK_CHANNEL_CONDITIONER_UNIT_MACROS_SVH

// condition holds in the same cycle
`define SCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scc_pkg.sv
// shared types and constants of the stick channel conditioner unit
// no dependencies
package scc_pkg;

  localparam int unsigned RAW_W     = 13;
  localparam int unsigned OUT_W     = 11;
  localparam int unsigned INV_W     = 10;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned ANALOG_CH = 4;
  localparam int unsigned DIV_STEPS = OUT_W;

  // reciprocals for span / 3 and span / 5, exact for spans below 2^16
  localparam int unsigned RECIP_W   = 18;
  localparam logic [RECIP_W-1:0] RECIP3 = 18'd43691;
  localparam int unsigned        SHIFT3 = 17;
  localparam logic [RECIP_W-1:0] RECIP5 = 18'd52429;
  localparam int unsigned        SHIFT5 = 18;

  localparam logic [OUT_W-1:0] OUT_START_RST = 11'd1844;
  localparam logic [OUT_W-1:0] OUT_END_RST   = 11'd204;

  typedef enum logic [1:0] {
    CFG_FLY_MODE    = 2'd0,
    CFG_INVERT_MASK = 2'd1,
    CFG_OUT_START   = 2'd2,
    CFG_OUT_END     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COND,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: sv/stick_channel_conditioner_unit.sv
// stick channel conditioner: inversion, clamping, limit learning, zones and mapping
// depends on scc_pkg and stick_channel_conditioner_unit_macros.svh

// One request carries a channel, a raw sample and a learn flag; one result comes
// back per request. The per-channel min and max limits live in a small synchronous
// memory with valid bits, so an entry never written reads as its reset limits at
// once after reset. A request is read from memory, conditioned and written back
// (learning), then multiplied and divided by the span with an 11-step serial
// divider. The next request is accepted only after the current one has left
// the divider loop and reached the output register; a request for a channel out
// of range skips the divider. The finished result sits in an output register, so
// the next request is taken while it waits.
module stick_channel_conditioner_unit #(
  parameter int unsigned NUM_CHANNELS = 10,
  parameter int unsigned FULL_SCALE   = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration writes
  input  logic                      cfg_we_i,
  input  scc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [scc_pkg::CFG_W-1:0] cfg_data_i,
  // request stream
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [23:0]               s_tdata_i,   // channel[3:0], raw_sample[16:4], zero pad
  input  logic                      s_tuser_i,   // learn
  // result stream
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [23:0]               m_tdata_o,   // conditioned_value[12:0], mapped_value[23:13]
  output logic [4:0]                m_tuser_o    // mapped_valid, centered, low_zone,
                                                 // high_zone, limits_changed
);
  import scc_pkg::*;

  localparam int unsigned FS_W   = $clog2(FULL_SCALE + 1);
  localparam int unsigned LIM_W  = (FS_W > RAW_W) ? FS_W : RAW_W;
  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned NUM_W  = LIM_W + OUT_W;
  localparam int unsigned PROD_W = LIM_W + RECIP_W;
  localparam int unsigned ZW     = LIM_W + 1;
  localparam logic [LIM_W-1:0] FS_VAL = LIM_W'(FULL_SCALE);
  localparam logic [LIM_W-1:0] SW_VAL = LIM_W'(1);

  // configuration registers
  logic             fly_q;
  logic [INV_W-1:0] inv_q;
  logic [OUT_W-1:0] ostart_q, oend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q    <= 1'b0;
      inv_q    <= '0;
      ostart_q <= OUT_START_RST;
      oend_q   <= OUT_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLY_MODE:    fly_q    <= cfg_data_i[0];
        CFG_INVERT_MASK: inv_q    <= cfg_data_i[INV_W-1:0];
        CFG_OUT_START:   ostart_q <= cfg_data_i[OUT_W-1:0];
        CFG_OUT_END:     oend_q   <= cfg_data_i[OUT_W-1:0];
        default:         ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;
  logic   accept, mem_we, out_load, m_valid_q;
  logic   oor_q, learn_q;
  logic [3:0] cnt_q;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d  = state_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_COND;
      ST_COND: begin
        mem_we  = learn_q && !oor_q;
        state_d = oor_q ? ST_DONE : ST_MUL;
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 4'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  logic [CHAN_W-1:0] ch_q;
  logic [RAW_W-1:0]  raw_q;
  logic              in_range;

  assign in_range = ({1'b0, s_tdata_i[CHAN_W-1:0]} < (CHAN_W + 1)'(NUM_CHANNELS));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q    <= s_tdata_i[CHAN_W-1:0];
      raw_q   <= s_tdata_i[CHAN_W +: RAW_W];
      learn_q <= s_tuser_i;
      oor_q   <= !in_range;
    end
  end

  // limit memory, entry is {min, max}
  logic [2*LIM_W-1:0]      mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [2*LIM_W-1:0]      rd_data_q;
  logic                    rd_vld_q;
  logic [LIM_W-1:0]        new_mn, new_mx;

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      rd_data_q <= mem_q[s_tdata_i[CH_W-1:0]];
    end
    if (mem_we) begin
      mem_q[ch_q[CH_W-1:0]] <= {new_mn, new_mx};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept && in_range) rd_vld_q <= vld_q[s_tdata_i[CH_W-1:0]];
      if (mem_we) vld_q[ch_q[CH_W-1:0]] <= 1'b1;
    end
  end

  // conditioning
  logic [LIM_W-1:0] mn, mx, raw_x, inv_v, pre_v, v, span;
  logic             inv_bit, lower, upper;

  always_comb begin
    if (rd_vld_q) begin
      mn = rd_data_q[LIM_W +: LIM_W];
      mx = rd_data_q[LIM_W-1:0];
    end else begin
      mn = '0;
      mx = (ch_q < CHAN_W'(ANALOG_CH)) ? FS_VAL : SW_VAL;
    end
    raw_x   = LIM_W'(raw_q);
    inv_bit = (ch_q < CHAN_W'(INV_W)) ? inv_q[ch_q] : 1'b0;
    inv_v   = (raw_x > mx) ? mx : mx - raw_x;
    pre_v   = inv_bit ? inv_v : raw_x;
    priority if (mn > pre_v) v = mn;
    else if (mx < pre_v)     v = mx;
    else                     v = pre_v;
    span    = (mx > mn) ? mx - mn : '0;
    lower   = mn > raw_x;
    upper   = !lower && (mx < raw_x);
    new_mn  = lower ? raw_x : mn;
    new_mx  = upper ? raw_x : mx;
  end

  logic [LIM_W-1:0] v_q, mn_q, mx_q, span_q;
  logic             changed_q, neg_q;
  logic [OUT_W-1:0] diff_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COND) begin
      v_q       <= v;
      mn_q      <= mn;
      mx_q      <= mx;
      span_q    <= span;
      changed_q <= learn_q && (lower || upper);
      neg_q     <= oend_q < ostart_q;
      diff_q    <= (oend_q < ostart_q) ? ostart_q - oend_q : oend_q - ostart_q;
    end
  end

  // products: mapping numerator and reciprocal divisions of the span
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] p3, p5;
  logic [LIM_W-1:0]  d3_q, d5_q;

  assign num = NUM_W'(v_q - mn_q) * NUM_W'(diff_q);
  assign p3  = PROD_W'(span_q) * PROD_W'(RECIP3);
  assign p5  = PROD_W'(span_q) * PROD_W'(RECIP5);

  // serial divider, quotient is known to fit OUT_W bits
  logic [LIM_W-1:0] rem_q;
  logic [OUT_W-1:0] num_lo_q, quo_q;
  logic [LIM_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, num_lo_q[OUT_W-1]};
  assign ge    = trial >= {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      rem_q    <= num[NUM_W-1:OUT_W];
      num_lo_q <= num[OUT_W-1:0];
      d3_q     <= p3[SHIFT3 +: LIM_W];
      d5_q     <= p5[SHIFT5 +: LIM_W];
      cnt_q    <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q    <= ge ? LIM_W'(trial - {1'b0, span_q}) : trial[LIM_W-1:0];
      num_lo_q <= {num_lo_q[OUT_W-2:0], 1'b0};
      quo_q    <= {quo_q[OUT_W-2:0], ge};
      cnt_q    <= cnt_q + 4'd1;
    end
  end

  // zones and mapped value
  logic [ZW-1:0]    vz, mid, lo5, hi5, lo3, hi3;
  logic [OUT_W-1:0] mapped;
  logic             centered, low_zone, high_zone;

  always_comb begin
    vz        = ZW'(v_q);
    mid       = ZW'(mn_q) + ZW'(span_q >> 1);
    lo5       = mid - ZW'(d5_q);
    hi5       = mid + ZW'(d5_q);
    lo3       = ZW'(mn_q) + ZW'(d3_q);
    hi3       = ZW'(mx_q) - ZW'(d3_q);
    centered  = !(vz < lo5 || vz > hi5);
    low_zone  = vz < lo3;
    high_zone = vz > hi3;
    if (!fly_q)              mapped = '0;
    else if (span_q == '0)   mapped = ostart_q;
    else if (neg_q)          mapped = ostart_q - quo_q;
    else                     mapped = ostart_q + quo_q;
  end

  // output register
  logic [23:0] m_data_q;
  logic [4:0]  m_user_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (oor_q) begin
        m_data_q <= '0;
        m_user_q <= '0;
      end else begin
        m_data_q <= {mapped, v_q[RAW_W-1:0]};
        m_user_q <= {changed_q, high_zone, low_zone, centered, fly_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  `include "stick_channel_conditioner_unit_macros.svh"

  `SCC_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_READ, "request not followed by read")
  `SCC_ASSERT_NOW(a_load_free, out_load, !m_valid_q || m_tready_i, "result register overwritten")
  `SCC_ASSERT_NOW(a_div_bound, state_q == ST_DIV, cnt_q < 4'(DIV_STEPS), "divider overran")
  `SCC_ASSERT_NOW(a_we_cond, mem_we, state_q == ST_COND && !oor_q, "stray limit write")
  `SCC_ASSERT_NOW(a_map_zero, m_valid_q && !m_user_q[0], m_data_q[23:13] == '0,
                  "mapped without fly")

endmodule
